// ----- hw/rtl/mas_pkg.sv -----
package mas_pkg;

    localparam int POS_W   = 11;
    localparam int RES_MAX = 5;
    localparam int RES_IW  = $clog2(RES_MAX);
    localparam int RES_CW  = $clog2(RES_MAX + 1);

    // configuration register indexes
    localparam logic CFG_TOKEN_MODE = 1'b0;
    localparam logic CFG_COMMA_MODE = 1'b1;

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    typedef enum logic [1:0] {
        KIND_BYTE   = 2'd0,
        KIND_REWIND = 2'd1,
        KIND_END    = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ANG_NONE   = 2'd0,
        ANG_INSIDE = 2'd1,
        ANG_AFTER  = 2'd2
    } t_angle;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_word;

    typedef struct packed {
        t_kind            kind;
        logic [7:0]       out_byte;
        logic [POS_W-1:0] position;
        logic             terminated;
        logic             overflow;
    } t_out_word;

endpackage

// ----- hw/rtl/mail_address_skinner.sv -----
// channel | direction | valid   | ready   | word
// input   | in        | i_valid | o_ready | i_data   (t_in_word)
// output  | out       | o_valid | i_ready | o_data   (t_out_word)
// config  | in        | i_cfg_wr_en  (no handshake) | i_cfg_index, i_cfg_data
//
// One input byte is parsed in the cycle it is accepted; its 0 to 5 result words
// land in a burst register and drain one per cycle, while i_ready allows, through
// the output register. A byte that yields at most one word is taken every cycle
// under that condition; a longer burst holds o_ready low until its last word loads.
// Reset is synchronous, active low, and clears parser state and configuration.
module mail_address_skinner #(
    parameter int MAX_LEN   = 1024,
    parameter int MAX_DEPTH = 31
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  mas_pkg::t_in_word   i_data,
    output logic                o_valid,
    input  logic                i_ready,
    output mas_pkg::t_out_word  o_data,
    input  logic                i_cfg_wr_en,
    input  logic                i_cfg_index,
    input  logic                i_cfg_data
);
    import mas_pkg::*;

    localparam int CW = $clog2(MAX_LEN + 1);
    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam logic [CW-1:0] MAX_LEN_C   = CW'(MAX_LEN);
    localparam logic [DW-1:0] MAX_DEPTH_C = DW'(MAX_DEPTH);

    logic r_token_mode, r_comma_mode;

    t_angle        r_ang;
    logic          r_ps, r_ic, r_iq, r_qo, r_esc, r_td, r_ovf;
    logic [DW-1:0] r_dep;
    logic [CW-1:0] r_oc, r_rm, r_inc;

    t_angle        n_ang;
    logic          n_ps, n_ic, n_iq, n_qo, n_esc, n_td, n_ovf;
    logic [DW-1:0] n_dep;
    logic [CW-1:0] n_oc, n_rm, n_inc;

    t_out_word         r_burst [RES_MAX];
    logic [RES_CW-1:0] r_cnt, r_idx;
    t_out_word         n_res [RES_MAX];
    logic [RES_CW-1:0] n_cnt;

    logic      r_out_valid;
    t_out_word r_out;
    logic      have, load_out, accept;

    function automatic t_out_word mk(t_kind kind, logic [7:0] b, logic [CW-1:0] pos,
                                     logic term, logic ovf);
        t_out_word w;
        logic [31:0] wide;
        wide         = 32'(pos);
        w.kind       = kind;
        w.out_byte   = b;
        w.position   = wide[POS_W-1:0];
        w.terminated = term;
        w.overflow   = ovf;
        return w;
    endfunction

    assign have     = (r_idx != r_cnt);
    assign load_out = have && (!r_out_valid || i_ready);
    assign o_ready  = !have || (load_out && (r_idx + RES_CW'(1) == r_cnt));
    assign accept   = i_valid && o_ready;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    // parse one byte
    always_comb begin
        logic [7:0]    c;
        logic [CW-1:0] idx;
        logic          is_ws, vis_req, vis_q;
        logic          do_rewind, do_endtok, do_mark;
        logic [2:0]    want;
        logic [7:0]    bytes [3];

        c         = i_data.data_byte;
        idx       = r_inc;
        is_ws     = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_NL);
        vis_req   = 1'b0;
        vis_q     = 1'b0;
        do_rewind = 1'b0;
        do_endtok = 1'b0;
        do_mark   = 1'b0;
        want      = '0;
        bytes[0]  = CH_SPACE;
        bytes[1]  = CH_DQUOTE;
        bytes[2]  = c;

        n_ang = r_ang;  n_ps = r_ps;   n_ic = r_ic;   n_iq = r_iq;
        n_qo  = r_qo;   n_esc = r_esc; n_td = r_td;   n_ovf = r_ovf;
        n_dep = r_dep;  n_oc = r_oc;   n_rm = r_rm;   n_inc = r_inc;
        n_cnt = '0;
        for (int i = 0; i < RES_MAX; i++) begin
            n_res[i] = mk(KIND_BYTE, 8'd0, '0, 1'b0, 1'b0);
        end

        if (!r_td) begin
            if (r_inc >= MAX_LEN_C) begin
                if (r_token_mode) begin
                    n_ovf = 1'b1;
                end
            end else begin
                n_inc = r_inc + CW'(1);
            end

            if (r_ic) begin
                if (r_esc) begin
                    n_esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (c == CH_LPAREN) begin
                    if (r_dep < MAX_DEPTH_C) begin
                        n_dep = r_dep + DW'(1);
                    end
                end else if (c == CH_RPAREN) begin
                    if (r_dep > DW'(1)) begin
                        n_dep = r_dep - DW'(1);
                    end else begin
                        n_dep = '0;
                        n_ic  = 1'b0;
                    end
                end
            end else if (r_iq) begin
                if (!r_esc && c == CH_BSLASH) begin
                    n_esc = 1'b1;
                end else if (!r_esc && c == CH_DQUOTE) begin
                    want[2] = r_qo;
                    n_qo    = 1'b0;
                    n_iq    = 1'b0;
                    n_ps    = 1'b0;
                end else begin
                    n_esc   = 1'b0;
                    vis_req = 1'b1;
                    vis_q   = 1'b1;
                end
            end else if (c == CH_LPAREN) begin
                n_ic  = 1'b1;
                n_dep = DW'(1);
                n_esc = 1'b0;
                n_ps  = 1'b0;
            end else if (c == CH_DQUOTE) begin
                n_iq  = 1'b1;
                n_qo  = 1'b0;
                n_esc = 1'b0;
            end else if (is_ws) begin
                if (r_token_mode && (!r_comma_mode || c == CH_NL)) begin
                    do_endtok = 1'b1;
                end else begin
                    n_ps = 1'b1;
                end
            end else if (c == CH_COMMA) begin
                want[2] = 1'b1;
                if (r_ang != ANG_INSIDE) begin
                    if (r_token_mode) begin
                        do_endtok = 1'b1;
                    end else begin
                        do_mark = 1'b1;
                    end
                end
            end else if (c == CH_LT) begin
                do_rewind = 1'b1;
                n_ang     = ANG_INSIDE;
                n_ps      = 1'b0;
            end else if (c == CH_GT && r_ang == ANG_INSIDE) begin
                n_ang = ANG_AFTER;
            end else begin
                vis_req = 1'b1;
            end

            // visible byte: flush pending space, open quote if needed
            if (vis_req && r_ang != ANG_AFTER) begin
                if (n_ps) begin
                    n_ps    = 1'b0;
                    want[0] = 1'b1;
                end
                if (vis_q && !n_qo) begin
                    want[1] = 1'b1;
                    n_qo    = 1'b1;
                end
                want[2] = 1'b1;
            end

            for (int s = 0; s < 3; s++) begin
                if (want[s] && !r_token_mode) begin
                    if (n_oc >= MAX_LEN_C) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_res[n_cnt[RES_IW-1:0]] = mk(KIND_BYTE, bytes[s], n_oc, 1'b0, 1'b0);
                        n_cnt = n_cnt + RES_CW'(1);
                        n_oc  = n_oc + CW'(1);
                    end
                end
            end

            if (do_mark) begin
                n_rm  = n_oc;
                n_ang = ANG_NONE;
            end
            if (do_rewind) begin
                n_oc = r_rm;
                if (!r_token_mode) begin
                    n_res[n_cnt[RES_IW-1:0]] = mk(KIND_REWIND, 8'd0, r_rm, 1'b0, 1'b0);
                    n_cnt = n_cnt + RES_CW'(1);
                end
            end
            if (do_endtok) begin
                n_res[n_cnt[RES_IW-1:0]] = mk(KIND_END, 8'd0, idx, 1'b1, n_ovf);
                n_cnt = n_cnt + RES_CW'(1);
                n_td  = 1'b1;
            end
        end

        if (i_data.last) begin
            if (!n_td) begin
                if (r_token_mode) begin
                    n_res[n_cnt[RES_IW-1:0]] = mk(KIND_END, 8'd0, n_inc, 1'b0, n_ovf);
                    n_cnt = n_cnt + RES_CW'(1);
                end else begin
                    if (n_iq && n_qo) begin
                        if (n_oc >= MAX_LEN_C) begin
                            n_ovf = 1'b1;
                        end else begin
                            n_res[n_cnt[RES_IW-1:0]] =
                                mk(KIND_BYTE, CH_DQUOTE, n_oc, 1'b0, 1'b0);
                            n_cnt = n_cnt + RES_CW'(1);
                            n_oc  = n_oc + CW'(1);
                        end
                    end
                    n_res[n_cnt[RES_IW-1:0]] = mk(KIND_END, 8'd0, n_oc, 1'b0, n_ovf);
                    n_cnt = n_cnt + RES_CW'(1);
                end
            end
            // drop all stream state at end of string
            n_ang = ANG_NONE; n_ps = 1'b0; n_ic = 1'b0; n_dep = '0;
            n_iq  = 1'b0;     n_qo = 1'b0; n_esc = 1'b0;
            n_oc  = '0;       n_rm = '0;   n_inc = '0; n_td = 1'b0; n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_token_mode <= 1'b0;
            r_comma_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_TOKEN_MODE: r_token_mode <= i_cfg_data;
                CFG_COMMA_MODE: r_comma_mode <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ang <= ANG_NONE;
            r_ps  <= 1'b0;
            r_ic  <= 1'b0;
            r_iq  <= 1'b0;
            r_qo  <= 1'b0;
            r_esc <= 1'b0;
            r_td  <= 1'b0;
            r_ovf <= 1'b0;
            r_dep <= '0;
            r_oc  <= '0;
            r_rm  <= '0;
            r_inc <= '0;
        end else if (accept) begin
            r_ang <= n_ang;
            r_ps  <= n_ps;
            r_ic  <= n_ic;
            r_iq  <= n_iq;
            r_qo  <= n_qo;
            r_esc <= n_esc;
            r_td  <= n_td;
            r_ovf <= n_ovf;
            r_dep <= n_dep;
            r_oc  <= n_oc;
            r_rm  <= n_rm;
            r_inc <= n_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
            r_idx <= '0;
        end else if (load_out) begin
            r_idx <= r_idx + RES_CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_burst <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_burst[r_idx[RES_IW-1:0]];
        end
    end

`ifndef NO_ASSERTIONS
    a_drain_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_idx <= r_cnt) && (r_cnt <= RES_CW'(RES_MAX)))
        else $error("burst drain index past word count");

    a_last_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_data.last) |=> (r_oc == '0) && (r_inc == '0) && !r_td && !r_ovf)
        else $error("stream state not cleared after last byte");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_oc <= MAX_LEN_C) && (r_rm <= r_oc) && (r_inc <= MAX_LEN_C))
        else $error("output counters out of range");

    a_comment_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ic == (r_dep != '0))
        else $error("comment flag and depth disagree");
`endif

endmodule

// ----- tb/mail_address_skinner_tb.sv -----
`timescale 1ns / 1ps

module mail_address_skinner_tb;

    import mas_pkg::*;

    localparam int MAX_LEN     = 1024;
    localparam int MAX_DEPTH   = 31;
    localparam int PHASE_ITEMS = 60;
    localparam int SETTLE      = 8;
    localparam int HOLD_CYCLES = 300;
    localparam int LONG_RUN    = MAX_LEN + 6;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        t_out_word  want;
    } t_row;

    localparam t_out_word NO_WORD = '0;

    // directed address: comments, an escaped quote inside quotes, a comma mark, a
    // route in angle brackets, text after '>', and a quote left open at the end
    localparam t_row DIRECTED [0:24] = '{
        '{"a",       1'b0, 1'b1, '{KIND_BYTE, "a", 11'd0, 1'b0, 1'b0}},
        '{CH_SPACE,  1'b0, 1'b0, NO_WORD},
        '{CH_LPAREN, 1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_RPAREN, 1'b0, 1'b0, NO_WORD},
        '{CH_LPAREN, 1'b0, 1'b0, NO_WORD},
        '{CH_RPAREN, 1'b0, 1'b0, NO_WORD},
        '{CH_RPAREN, 1'b0, 1'b0, NO_WORD},
        '{"b",       1'b0, 1'b0, NO_WORD},
        '{CH_DQUOTE, 1'b0, 1'b0, NO_WORD},
        '{CH_BSLASH, 1'b0, 1'b0, NO_WORD},
        '{CH_DQUOTE, 1'b0, 1'b0, NO_WORD},
        '{"x",       1'b0, 1'b0, NO_WORD},
        '{CH_COMMA,  1'b0, 1'b0, NO_WORD},
        '{CH_DQUOTE, 1'b0, 1'b0, NO_WORD},
        '{CH_COMMA,  1'b0, 1'b0, NO_WORD},
        '{8'hFF,     1'b0, 1'b1, '{KIND_BYTE, 8'hFF, 11'd8, 1'b0, 1'b0}},
        '{CH_LT,     1'b0, 1'b1, '{KIND_REWIND, 8'h00, 11'd8, 1'b0, 1'b0}},
        '{8'h01,     1'b0, 1'b1, '{KIND_BYTE, 8'h01, 11'd8, 1'b0, 1'b0}},
        '{CH_GT,     1'b0, 1'b0, NO_WORD},
        '{"z",       1'b0, 1'b0, NO_WORD},
        '{CH_COMMA,  1'b0, 1'b0, NO_WORD},
        '{CH_TAB,    1'b0, 1'b0, NO_WORD},
        '{CH_DQUOTE, 1'b0, 1'b0, NO_WORD},
        '{"q",       1'b1, 1'b0, NO_WORD}
    };

    logic      i_clk;
    logic      i_rst_n     = 1'b0;
    logic      i_valid     = 1'b0;
    logic      o_ready;
    t_in_word  i_data      = '0;
    logic      o_valid;
    logic      i_ready     = 1'b0;
    t_out_word o_data;
    logic      i_cfg_wr_en = 1'b0;
    logic      i_cfg_index = CFG_TOKEN_MODE;
    logic      i_cfg_data  = 1'b0;

    // skinner model state
    logic       tok_mode, comma_only;
    t_angle     sk_angle;
    logic       sk_space, sk_cmt, sk_quote, sk_qopen, sk_esc, sk_tdone, sk_ovf;
    logic [4:0] sk_depth;
    logic [10:0] sk_out, sk_mark, sk_in;

    t_out_word  due_words[$];
    logic [7:0] addr_bytes[$];

    int snd_idle   = 0;
    int rcv_stall  = 0;
    int hold_asks  = 0;
    int hold_taken = 0;
    int hold_left  = 0;
    int mismatches = 0;

    mail_address_skinner #(
        .MAX_LEN  (MAX_LEN),
        .MAX_DEPTH(MAX_DEPTH)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("** mail_address_skinner: FAILED **");
        $finish;
    end

    task automatic clear_stream();
        sk_angle = ANG_NONE;
        sk_space = 1'b0;
        sk_cmt   = 1'b0;
        sk_depth = '0;
        sk_quote = 1'b0;
        sk_qopen = 1'b0;
        sk_esc   = 1'b0;
        sk_out   = '0;
        sk_mark  = '0;
        sk_in    = '0;
        sk_tdone = 1'b0;
        sk_ovf   = 1'b0;
    endtask

    task automatic add_due(t_kind k, logic [7:0] b, logic [10:0] pos, logic term, logic ovf);
        t_out_word w;
        w.kind       = k;
        w.out_byte   = b;
        w.position   = pos;
        w.terminated = term;
        w.overflow   = ovf;
        due_words.push_back(w);
    endtask

    task automatic put_out(logic [7:0] c);
        if (!tok_mode) begin
            if (sk_out >= MAX_LEN) begin
                sk_ovf = 1'b1;
            end else begin
                add_due(KIND_BYTE, c, sk_out, 1'b0, 1'b0);
                sk_out++;
            end
        end
    endtask

    task automatic put_vis(logic [7:0] c, logic quoted);
        if (sk_angle != ANG_AFTER) begin
            if (sk_space) begin
                sk_space = 1'b0;
                put_out(CH_SPACE);
            end
            if (quoted && !sk_qopen) begin
                put_out(CH_DQUOTE);
                sk_qopen = 1'b1;
            end
            put_out(c);
        end
    endtask

    task automatic end_token(logic [10:0] len);
        add_due(KIND_END, 8'h00, len, 1'b1, sk_ovf);
        sk_tdone = 1'b1;
    endtask

    // advance the skinner by one byte and queue the words it should produce
    task automatic skin_byte(logic [7:0] c, logic fin);
        logic [10:0] idx;
        if (!sk_tdone) begin
            idx = sk_in;
            if (sk_in >= MAX_LEN) begin
                if (tok_mode) sk_ovf = 1'b1;
            end else begin
                sk_in++;
            end
            if (sk_cmt) begin
                if (sk_esc) begin
                    sk_esc = 1'b0;
                end else if (c == CH_BSLASH) begin
                    sk_esc = 1'b1;
                end else if (c == CH_LPAREN) begin
                    if (sk_depth < MAX_DEPTH) sk_depth++;
                end else if (c == CH_RPAREN) begin
                    if (sk_depth > 0) sk_depth--;
                    if (sk_depth == 0) sk_cmt = 1'b0;
                end
            end else if (sk_quote) begin
                if (sk_esc) begin
                    sk_esc = 1'b0;
                    put_vis(c, 1'b1);
                end else if (c == CH_BSLASH) begin
                    sk_esc = 1'b1;
                end else if (c == CH_DQUOTE) begin
                    if (sk_qopen) put_out(CH_DQUOTE);
                    sk_qopen = 1'b0;
                    sk_quote = 1'b0;
                    sk_space = 1'b0;
                end else begin
                    put_vis(c, 1'b1);
                end
            end else if (c == CH_LPAREN) begin
                sk_cmt   = 1'b1;
                sk_depth = 5'd1;
                sk_esc   = 1'b0;
                sk_space = 1'b0;
            end else if (c == CH_DQUOTE) begin
                sk_quote = 1'b1;
                sk_qopen = 1'b0;
                sk_esc   = 1'b0;
            end else if (c == CH_SPACE || c == CH_TAB || c == CH_NL) begin
                if (tok_mode && (!comma_only || c == CH_NL)) end_token(idx);
                else sk_space = 1'b1;
            end else if (c == CH_COMMA) begin
                put_out(CH_COMMA);
                if (sk_angle != ANG_INSIDE) begin
                    if (tok_mode) begin
                        end_token(idx);
                    end else begin
                        sk_mark  = sk_out;
                        sk_angle = ANG_NONE;
                    end
                end
            end else if (c == CH_LT) begin
                sk_out = sk_mark;
                if (!tok_mode) add_due(KIND_REWIND, 8'h00, sk_mark, 1'b0, 1'b0);
                sk_angle = ANG_INSIDE;
                sk_space = 1'b0;
            end else if (c == CH_GT && sk_angle == ANG_INSIDE) begin
                sk_angle = ANG_AFTER;
            end else begin
                put_vis(c, 1'b0);
            end
        end
        if (fin) begin
            if (!sk_tdone) begin
                if (tok_mode) begin
                    add_due(KIND_END, 8'h00, sk_in, 1'b0, sk_ovf);
                end else begin
                    if (sk_quote && sk_qopen) put_out(CH_DQUOTE);
                    add_due(KIND_END, 8'h00, sk_out, 1'b0, sk_ovf);
                end
            end
            clear_stream();
        end
    endtask

    task automatic send_char(logic [7:0] c, logic fin, logic typed, t_out_word typed_word);
        int n0;
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= '{data_byte: c, last: fin};
        do @(posedge i_clk); while (!o_ready);
        n0 = due_words.size();
        skin_byte(c, fin);
        if (typed) begin
            while (due_words.size() > n0) void'(due_words.pop_back());
            due_words.push_back(typed_word);
        end
    endtask

    // drop valid and hold until every queued word has come back
    task automatic drain();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (due_words.size() != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic set_mode(logic tm, logic cm);
        drain();
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= CFG_TOKEN_MODE;
        i_cfg_data  <= tm;
        @(posedge i_clk);
        i_cfg_index <= CFG_COMMA_MODE;
        i_cfg_data  <= cm;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        tok_mode   = tm;
        comma_only = cm;
    endtask

    function automatic logic [7:0] rand_letter();
        case ($urandom_range(0, 9))
            0:       return "@";
            1:       return ".";
            default: return 8'("a") + 8'($urandom_range(0, 25));
        endcase
    endfunction

    function automatic logic [7:0] rand_blank();
        case ($urandom_range(0, 2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_NL;
        endcase
    endfunction

    // mostly well-formed address lists with random content, some raw noise
    task automatic build_address();
        int d;
        addr_bytes.delete();
        if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 10)) addr_bytes.push_back(8'($urandom_range(1, 255)));
        end else begin
            repeat ($urandom_range(1, 6)) begin
                case ($urandom_range(0, 8))
                    0, 1: repeat ($urandom_range(1, 6)) addr_bytes.push_back(rand_letter());
                    2: repeat ($urandom_range(1, 3)) addr_bytes.push_back(rand_blank());
                    3: begin
                        d = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_DEPTH - 1, MAX_DEPTH + 4)
                                                        : $urandom_range(1, 3);
                        repeat (d) addr_bytes.push_back(CH_LPAREN);
                        repeat ($urandom_range(0, 3)) begin
                            if ($urandom_range(0, 2) == 0) begin
                                addr_bytes.push_back(CH_BSLASH);
                                addr_bytes.push_back(8'($urandom_range(1, 255)));
                            end else begin
                                addr_bytes.push_back(rand_letter());
                            end
                        end
                        repeat (d) addr_bytes.push_back(CH_RPAREN);
                    end
                    4: begin
                        addr_bytes.push_back(CH_DQUOTE);
                        repeat ($urandom_range(0, 4)) begin
                            case ($urandom_range(0, 4))
                                0: addr_bytes.push_back(rand_blank());
                                1: addr_bytes.push_back(CH_COMMA);
                                2: begin
                                    addr_bytes.push_back(CH_BSLASH);
                                    addr_bytes.push_back($urandom_range(0, 1) ? CH_DQUOTE
                                                                              : CH_BSLASH);
                                end
                                default: addr_bytes.push_back(rand_letter());
                            endcase
                        end
                        if ($urandom_range(0, 9) != 0) addr_bytes.push_back(CH_DQUOTE);
                    end
                    5: begin
                        addr_bytes.push_back(CH_LT);
                        repeat ($urandom_range(1, 5)) addr_bytes.push_back(rand_letter());
                        if ($urandom_range(0, 9) != 0) addr_bytes.push_back(CH_GT);
                    end
                    6, 7: addr_bytes.push_back(CH_COMMA);
                    default: addr_bytes.push_back(8'($urandom_range(1, 255)));
                endcase
            end
        end
    endtask

    task automatic run_phase(logic tm, logic cm, int snd, int rcv, logic hold, logic pause);
        int sent;
        set_mode(tm, cm);
        snd_idle  = snd;
        rcv_stall = rcv;
        if (hold) hold_asks++;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            build_address();
            foreach (addr_bytes[i])
                send_char(addr_bytes[i], i == addr_bytes.size() - 1, 1'b0, NO_WORD);
            if (pause && sent == 0) drain();
            sent += addr_bytes.size();
        end
    endtask

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rcv_stall);
        end
    end

    task automatic flag_field(string name, int unsigned want, int unsigned got);
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (due_words.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, o_data);
                mismatches++;
            end else begin
                want = due_words.pop_front();
                if (o_data.kind !== want.kind) flag_field("kind", want.kind, o_data.kind);
                if (o_data.out_byte !== want.out_byte)
                    flag_field("out_byte", want.out_byte, o_data.out_byte);
                if (o_data.position !== want.position)
                    flag_field("position", want.position, o_data.position);
                if (o_data.terminated !== want.terminated)
                    flag_field("terminated", want.terminated, o_data.terminated);
                if (o_data.overflow !== want.overflow)
                    flag_field("overflow", want.overflow, o_data.overflow);
            end
        end
    end

    initial begin
        tok_mode   = 1'b0;
        comma_only = 1'b0;
        clear_stream();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[i])
            send_char(DIRECTED[i].ch, DIRECTED[i].fin, DIRECTED[i].typed, DIRECTED[i].want);

        run_phase(1'b0, 1'b0, 0,  0,  1'b0, 1'b0);
        run_phase(1'b1, 1'b0, 76, 0,  1'b0, 1'b0);
        run_phase(1'b0, 1'b1, 0,  76, 1'b1, 1'b0);
        run_phase(1'b1, 1'b1, 27, 27, 1'b0, 1'b1);
        run_phase(1'b0, 1'b0, 27, 27, 1'b0, 1'b0);

        // fill the output past its limit, then rewind: the overflow flag must stick
        set_mode(1'b0, 1'b0);
        snd_idle  = 0;
        rcv_stall = 0;
        repeat (LONG_RUN) send_char("b", 1'b0, 1'b0, NO_WORD);
        send_char(CH_LT, 1'b0, 1'b0, NO_WORD);
        send_char("c", 1'b1, 1'b0, NO_WORD);

        // token longer than the MAX_LEN input limit
        set_mode(1'b1, 1'b1);
        repeat (LONG_RUN) send_char("a", 1'b0, 1'b0, NO_WORD);
        send_char("a", 1'b1, 1'b0, NO_WORD);

        drain();
        if (mismatches == 0) begin
            $display("** mail_address_skinner: PASSED **");
        end else begin
            $display("** mail_address_skinner: FAILED **");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/mas_pkg.sv
hw/rtl/mail_address_skinner.sv
tb/mail_address_skinner_tb.sv
